// ===== hdl/cll_pkg.sv =====
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types and constants for the cursor linked list with free list.
// ----------------------------------------------------------------------------
package cll_pkg;
   localparam int NODES = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IW = $clog2(NODES + 1);
   localparam int AW = $clog2(NODES);
   localparam logic [IW-1:0] NONE = IW'(NODES);
   localparam logic [IW-1:0] IDX_ONE = IW'(1);

   typedef logic [IW-1:0] idx_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   localparam logic [3:0] K_INS_FRONT = 4'd0;
   localparam logic [3:0] K_INS_REAR  = 4'd1;
   localparam logic [3:0] K_RM_FRONT  = 4'd2;
   localparam logic [3:0] K_RM_REAR   = 4'd3;
   localparam logic [3:0] K_RM_CUR    = 4'd4;
   localparam logic [3:0] K_SEARCH    = 4'd5;
   localparam logic [3:0] K_RETRIEVE  = 4'd6;
   localparam logic [3:0] K_CLEAR     = 4'd7;
   localparam logic [3:0] K_PURGE     = 4'd8;
   localparam logic [3:0] K_READ      = 4'd9;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // node store port bundle
   typedef struct packed {
      logic    wr_data;
      logic    wr_next;
      logic [AW-1:0] waddr;
      data_type wdata;
      idx_type  wnext;
      logic [AW-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      data_type rdata;
      idx_type  rnext;
   } mem_rsp_type;
endpackage

// ===== hdl/cursor_linked_list_free_list_unit.sv =====
// Read, full and empty cases go straight to the response; an insert takes a node
// from the free list, else at the high-water mark. Rear insert, rear/current
// remove, search and retrieve walk the list node by node; clear frees one node at
// a time and purge compares every pair of nodes, removing later duplicates.
// One request at a time: busy is high until the strobe, next accepted in that cycle.
// Synchronous reset empties the list and sets the mask to all ones; no stalls.
// ----------------------------------------------------------------------------
// cursor_linked_list_free_list_unit
// Sequencer walking the node store for list operations with a free list.
// ----------------------------------------------------------------------------
module cursor_linked_list_free_list_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_kind,
   input  logic [31:0] req_data_word,
   input  logic [5:0]  req_position,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_node_index,
   output logic [6:0]  rsp_cursor_index,
   output logic [31:0] rsp_cursor_data
);
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_TAKE_RD, S_TAKE_WT, S_NEW_W, S_WALK_RD, S_WALK_WT,
      S_LINK_W, S_RMF_RD, S_RMF_WT, S_RMF_W, S_RMR_RD, S_RMR_WT, S_RMC_RD,
      S_RMC_WT, S_RMC_NX_RD, S_RMC_NX_WT, S_UNLINK_W, S_GIVE_W, S_SRCH_RD,
      S_SRCH_WT, S_OUT_RD, S_OUT_WT, S_CMP_RD, S_CMP_WT, S_PRG_W, S_PRG_G,
      S_CUR_RD, S_CUR_WT
   } state_type;

   state_type state_ff;
   logic [3:0] kind_ff;
   cll_pkg::data_type key_ff, mask_ff, pdata_ff;
   logic [5:0] pos_ff;
   logic [5:0] cnt_ff;
   cll_pkg::idx_type head_ff, cursor_ff, hw_ff, free_ff;
   cll_pkg::idx_type p_ff, q_ff, r_ff, rn_ff, new_ff, pnext_ff, idx_ff;
   logic [1:0] status_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   cll_pkg::idx_type rsp_node_ff, rsp_cursor_ff;
   cll_pkg::data_type rsp_cdata_ff;
   cll_pkg::mem_req_type mreq;
   cll_pkg::mem_rsp_type mrsp;
   logic match;

   cll_node_store u_store (.clock(clock), .req(mreq), .rsp(mrsp));

   // one shared masked compare: purge key while comparing, else request key
   assign match = (((mrsp.rdata ^ ((state_ff == S_CMP_WT) ? pdata_ff : key_ff))
                    & mask_ff) == '0);
   assign busy = (state_ff != S_IDLE);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_node_index = rsp_node_ff;
   assign rsp_cursor_index = rsp_cursor_ff;
   assign rsp_cursor_data = rsp_cdata_ff;

   function automatic logic [cll_pkg::AW-1:0] addr_of(cll_pkg::idx_type i);
      return i[cll_pkg::AW-1:0];
   endfunction

   always_comb begin
      mreq = '0;
      unique case (state_ff)
         S_TAKE_RD: mreq.raddr = addr_of(free_ff);
         S_RMF_RD:  mreq.raddr = addr_of(head_ff);
         S_WALK_RD, S_RMC_RD, S_SRCH_RD, S_OUT_RD: mreq.raddr = addr_of(p_ff);
         S_RMR_RD:  mreq.raddr = addr_of(q_ff);
         S_CMP_RD:  mreq.raddr = addr_of(r_ff);
         S_RMC_NX_RD, S_CUR_RD: mreq.raddr = addr_of(cursor_ff);
         S_NEW_W: begin
            mreq.wr_data = 1'b1; mreq.wr_next = 1'b1; mreq.waddr = addr_of(new_ff);
            mreq.wdata = key_ff;
            mreq.wnext = (kind_ff == cll_pkg::K_INS_FRONT) ? head_ff : cll_pkg::NONE;
         end
         S_LINK_W: begin
            mreq.wr_next = 1'b1; mreq.waddr = addr_of(p_ff); mreq.wnext = new_ff;
         end
         S_RMF_W: begin
            mreq.wr_next = 1'b1; mreq.waddr = addr_of(head_ff); mreq.wnext = free_ff;
         end
         S_UNLINK_W: begin
            mreq.wr_next = 1'b1; mreq.waddr = addr_of(p_ff); mreq.wnext = rn_ff;
         end
         S_GIVE_W, S_PRG_G: begin
            mreq.wr_next = 1'b1; mreq.waddr = addr_of(r_ff); mreq.wnext = free_ff;
         end
         S_PRG_W: begin
            mreq.wr_next = 1'b1; mreq.waddr = addr_of(q_ff); mreq.wnext = rn_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= cll_pkg::NONE; cursor_ff <= cll_pkg::NONE;
         hw_ff <= '0; free_ff <= cll_pkg::NONE;
         mask_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) mask_ff <= csr_wdata;
         rsp_valid_ff <= (state_ff == S_CUR_WT);
         unique case (state_ff)
            S_IDLE: if (start) begin
               kind_ff <= req_kind; key_ff <= req_data_word; pos_ff <= req_position;
               status_ff <= cll_pkg::ST_OK; idx_ff <= cll_pkg::NONE;
               cnt_ff <= '0;
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               unique case (kind_ff) inside
                  cll_pkg::K_INS_FRONT, cll_pkg::K_INS_REAR: begin
                     if (free_ff != cll_pkg::NONE) state_ff <= S_TAKE_RD;
                     else if (hw_ff != cll_pkg::NONE) begin
                        new_ff <= hw_ff; hw_ff <= hw_ff + cll_pkg::IDX_ONE;
                        state_ff <= S_NEW_W;
                     end else begin
                        status_ff <= cll_pkg::ST_FULL; state_ff <= S_CUR_RD;
                     end
                  end
                  cll_pkg::K_RM_FRONT: begin
                     if (head_ff == cll_pkg::NONE) begin
                        status_ff <= cll_pkg::ST_EMPTY; state_ff <= S_CUR_RD;
                     end else state_ff <= S_RMF_RD;
                  end
                  cll_pkg::K_CLEAR: begin
                     if (head_ff == cll_pkg::NONE) begin
                        cursor_ff <= cll_pkg::NONE; state_ff <= S_CUR_RD;
                     end else state_ff <= S_RMF_RD;
                  end
                  cll_pkg::K_RM_REAR: begin
                     if (head_ff == cll_pkg::NONE) begin
                        status_ff <= cll_pkg::ST_EMPTY; state_ff <= S_CUR_RD;
                     end else begin
                        p_ff <= cll_pkg::NONE; q_ff <= head_ff; state_ff <= S_RMR_RD;
                     end
                  end
                  cll_pkg::K_RM_CUR: begin
                     if (head_ff == cll_pkg::NONE || cursor_ff == cll_pkg::NONE) begin
                        status_ff <= cll_pkg::ST_EMPTY; state_ff <= S_CUR_RD;
                     end else if (cursor_ff == head_ff) state_ff <= S_RMF_RD;
                     else begin
                        p_ff <= head_ff; r_ff <= cursor_ff; state_ff <= S_RMC_RD;
                     end
                  end
                  cll_pkg::K_SEARCH, cll_pkg::K_RETRIEVE: begin
                     p_ff <= head_ff; state_ff <= S_SRCH_RD;
                  end
                  cll_pkg::K_PURGE: begin
                     p_ff <= head_ff; state_ff <= S_OUT_RD;
                  end
                  default: begin
                     idx_ff <= cursor_ff;
                     status_ff <= (cursor_ff != cll_pkg::NONE) ? cll_pkg::ST_OK
                                                               : cll_pkg::ST_EMPTY;
                     state_ff <= S_CUR_RD;
                  end
               endcase
            end
            S_TAKE_RD: state_ff <= S_TAKE_WT;
            S_TAKE_WT: begin
               new_ff <= free_ff; free_ff <= mrsp.rnext; state_ff <= S_NEW_W;
            end
            S_NEW_W: begin
               idx_ff <= new_ff; cursor_ff <= new_ff;
               if (kind_ff == cll_pkg::K_INS_FRONT || head_ff == cll_pkg::NONE) begin
                  head_ff <= new_ff; state_ff <= S_CUR_RD;
               end else begin
                  p_ff <= head_ff; state_ff <= S_WALK_RD;
               end
            end
            S_WALK_RD: state_ff <= S_WALK_WT;
            S_WALK_WT: begin
               if (mrsp.rnext == cll_pkg::NONE) state_ff <= S_LINK_W;
               else begin
                  p_ff <= mrsp.rnext; state_ff <= S_WALK_RD;
               end
            end
            S_LINK_W: state_ff <= S_CUR_RD;
            S_RMF_RD: state_ff <= S_RMF_WT;
            S_RMF_WT: begin
               rn_ff <= mrsp.rnext; state_ff <= S_RMF_W;
            end
            S_RMF_W: begin
               free_ff <= head_ff; head_ff <= rn_ff; cursor_ff <= rn_ff;
               if (kind_ff == cll_pkg::K_CLEAR) begin
                  state_ff <= (rn_ff == cll_pkg::NONE) ? S_CUR_RD : S_RMF_RD;
               end else begin
                  idx_ff <= head_ff; state_ff <= S_CUR_RD;
               end
            end
            // rear walk: q_ff is the node read, p_ff its predecessor
            S_RMR_RD: state_ff <= S_RMR_WT;
            S_RMR_WT: begin
               if (mrsp.rnext == cll_pkg::NONE) begin
                  rn_ff <= cll_pkg::NONE;
                  if (p_ff == cll_pkg::NONE) state_ff <= S_RMF_W;
                  else begin
                     r_ff <= q_ff; state_ff <= S_UNLINK_W;
                  end
               end else begin
                  p_ff <= q_ff; q_ff <= mrsp.rnext; state_ff <= S_RMR_RD;
               end
            end
            // current: walk to the predecessor of the cursor
            S_RMC_RD: state_ff <= S_RMC_WT;
            S_RMC_WT: begin
               if (mrsp.rnext == cursor_ff) state_ff <= S_RMC_NX_RD;
               else if (mrsp.rnext == cll_pkg::NONE) begin
                  status_ff <= cll_pkg::ST_EMPTY; state_ff <= S_CUR_RD;
               end else begin
                  p_ff <= mrsp.rnext; state_ff <= S_RMC_RD;
               end
            end
            S_RMC_NX_RD: state_ff <= S_RMC_NX_WT;
            S_RMC_NX_WT: begin
               rn_ff <= mrsp.rnext; state_ff <= S_UNLINK_W;
            end
            S_UNLINK_W: state_ff <= S_GIVE_W;
            S_GIVE_W: begin
               free_ff <= r_ff; idx_ff <= r_ff; cursor_ff <= p_ff; state_ff <= S_CUR_RD;
            end
            S_SRCH_RD: begin
               if (p_ff == cll_pkg::NONE) begin
                  status_ff <= cll_pkg::ST_EMPTY; state_ff <= S_CUR_RD;
               end else state_ff <= S_SRCH_WT;
            end
            S_SRCH_WT: begin
               if (kind_ff == cll_pkg::K_SEARCH) begin
                  if (match) begin
                     idx_ff <= p_ff; cursor_ff <= p_ff; state_ff <= S_CUR_RD;
                  end else begin
                     p_ff <= mrsp.rnext; state_ff <= S_SRCH_RD;
                  end
               end else begin
                  if (cnt_ff == pos_ff) begin
                     idx_ff <= p_ff; state_ff <= S_CUR_RD;
                  end else begin
                     cnt_ff <= cnt_ff + 6'd1; p_ff <= mrsp.rnext; state_ff <= S_SRCH_RD;
                  end
               end
            end
            // purge: p_ff outer node, q_ff keeps, r_ff candidate after q_ff
            S_OUT_RD: state_ff <= (p_ff == cll_pkg::NONE) ? S_CUR_RD : S_OUT_WT;
            S_OUT_WT: begin
               pdata_ff <= mrsp.rdata; q_ff <= p_ff; r_ff <= mrsp.rnext;
               pnext_ff <= mrsp.rnext; state_ff <= S_CMP_RD;
            end
            S_CMP_RD: begin
               if (r_ff == cll_pkg::NONE) begin
                  p_ff <= pnext_ff; state_ff <= S_OUT_RD;
               end else state_ff <= S_CMP_WT;
            end
            S_CMP_WT: begin
               if (match) begin
                  rn_ff <= mrsp.rnext; state_ff <= S_PRG_W;
               end else begin
                  q_ff <= r_ff; r_ff <= mrsp.rnext; state_ff <= S_CMP_RD;
               end
            end
            S_PRG_W: begin
               if (q_ff == p_ff) pnext_ff <= rn_ff;
               state_ff <= S_PRG_G;
            end
            S_PRG_G: begin
               free_ff <= r_ff; cursor_ff <= q_ff; r_ff <= rn_ff; state_ff <= S_CMP_RD;
            end
            S_CUR_RD: state_ff <= S_CUR_WT;
            S_CUR_WT: begin
               rsp_status_ff <= status_ff;
               rsp_node_ff <= idx_ff;
               rsp_cursor_ff <= cursor_ff;
               rsp_cdata_ff <= (cursor_ff == cll_pkg::NONE) ? '0 : mrsp.rdata;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/cll_node_store.sv =====
// ----------------------------------------------------------------------------
// cll_node_store
// Node pool: data and next-link memories, one write and one registered read.
// ----------------------------------------------------------------------------
module cll_node_store (
   input  logic                 clock,
   input  cll_pkg::mem_req_type req,
   output cll_pkg::mem_rsp_type rsp
);
   cll_pkg::data_type data_mem [cll_pkg::NODES];
   cll_pkg::idx_type  next_mem [cll_pkg::NODES];

   always_ff @(posedge clock) begin
      if (req.wr_data) data_mem[req.waddr] <= req.wdata;
      if (req.wr_next) next_mem[req.waddr] <= req.wnext;
      rsp.rdata <= data_mem[req.raddr];
      rsp.rnext <= next_mem[req.raddr];
   end
endmodule

// ===== tb/sv/cursor_linked_list_free_list_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_linked_list_free_list_unit_test
// Drives list requests through the command port and checks every response
// against a predictor of the node pool, free list and cursor held here.
// ----------------------------------------------------------------------------
module cursor_linked_list_free_list_unit_test;
   localparam int LIMIT = 200000;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] word;
      logic [5:0]  pos;
      logic        is_cfg;
      logic        drain;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  node;
      logic [6:0]  cur;
      logic [31:0] cdata;
   } answer_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [3:0]  req_kind = '0;
   logic [31:0] req_data_word = '0;
   logic [5:0]  req_position = '0;
   logic        csr_we = 0;
   logic [31:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_node_index;
   logic [6:0]  rsp_cursor_index;
   logic [31:0] rsp_cursor_data;

   cursor_linked_list_free_list_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_data_word(req_data_word),
      .req_position(req_position), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_node_index(rsp_node_index), .rsp_cursor_index(rsp_cursor_index),
      .rsp_cursor_data(rsp_cursor_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [31:0] pool_data [cll_pkg::NODES];
   logic [6:0]  pool_next [cll_pkg::NODES];
   logic [6:0]  head_q, cur_q, free_q;
   int          water_q;
   logic [31:0] mask_q;

   request_type pending_q [$];
   answer_type  awaited_q [$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  calm = 0;
   bit  stim_done = 0;

   function automatic logic [6:0] link(logic [6:0] i);
      return (i < cll_pkg::NODES) ? pool_next[i[5:0]] : cll_pkg::NONE;
   endfunction

   function automatic bit alike(logic [31:0] a, logic [31:0] b);
      return ((a ^ b) & mask_q) == 0;
   endfunction

   function automatic logic [6:0] take_node();
      logic [6:0] r;
      if (free_q < cll_pkg::NODES) begin
         r = free_q;
         free_q = pool_next[r[5:0]];
         return r;
      end
      if (water_q < cll_pkg::NODES) begin
         water_q++;
         return 7'(water_q - 1);
      end
      return cll_pkg::NONE;
   endfunction

   function automatic void give_node(logic [6:0] i);
      if (i >= cll_pkg::NODES) return;
      pool_next[i[5:0]] = free_q;
      free_q = i;
   endfunction

   function automatic logic [6:0] push_front(logic [31:0] d);
      logic [6:0] r;
      r = take_node();
      if (r >= cll_pkg::NODES) return cll_pkg::NONE;
      pool_data[r[5:0]] = d;
      pool_next[r[5:0]] = head_q;
      head_q = r;
      cur_q = r;
      return r;
   endfunction

   function automatic logic [6:0] pop_front();
      logic [6:0] h;
      h = head_q;
      if (h >= cll_pkg::NODES) return cll_pkg::NONE;
      head_q = pool_next[h[5:0]];
      give_node(h);
      cur_q = head_q;
      return h;
   endfunction

   function automatic answer_type predict_list_op(request_type rq);
      answer_type a;
      logic [1:0] st;
      logic [6:0] idx, p, q, r;
      st = cll_pkg::ST_OK;
      idx = cll_pkg::NONE;
      case (rq.kind)
         cll_pkg::K_INS_FRONT: begin
            idx = push_front(rq.word);
            if (idx == cll_pkg::NONE) st = cll_pkg::ST_FULL;
         end
         cll_pkg::K_INS_REAR: begin
            if (head_q >= cll_pkg::NODES) idx = push_front(rq.word);
            else begin
               p = head_q;
               for (int n = 0; n < cll_pkg::NODES && link(p) < cll_pkg::NODES; n++)
                  p = pool_next[p[5:0]];
               idx = take_node();
               if (idx < cll_pkg::NODES) begin
                  pool_data[idx[5:0]] = rq.word;
                  pool_next[idx[5:0]] = cll_pkg::NONE;
                  pool_next[p[5:0]] = idx;
                  cur_q = idx;
               end
            end
            if (idx == cll_pkg::NONE) st = cll_pkg::ST_FULL;
         end
         cll_pkg::K_RM_FRONT: begin
            idx = pop_front();
            if (idx == cll_pkg::NONE) st = cll_pkg::ST_EMPTY;
         end
         cll_pkg::K_RM_REAR: begin
            if (head_q >= cll_pkg::NODES) st = cll_pkg::ST_EMPTY;
            else if (pool_next[head_q[5:0]] >= cll_pkg::NODES) idx = pop_front();
            else begin
               p = head_q;
               q = pool_next[p[5:0]];
               for (int n = 0; n < cll_pkg::NODES && link(q) < cll_pkg::NODES; n++) begin
                  p = q;
                  q = pool_next[q[5:0]];
               end
               pool_next[p[5:0]] = cll_pkg::NONE;
               give_node(q);
               cur_q = p;
               idx = q;
            end
         end
         cll_pkg::K_RM_CUR: begin
            if (head_q >= cll_pkg::NODES || cur_q >= cll_pkg::NODES) st = cll_pkg::ST_EMPTY;
            else if (cur_q == head_q) idx = pop_front();
            else begin
               p = head_q;
               for (int n = 0; n < cll_pkg::NODES && p < cll_pkg::NODES &&
                    pool_next[p[5:0]] != cur_q; n++)
                  p = pool_next[p[5:0]];
               if (p < cll_pkg::NODES && pool_next[p[5:0]] == cur_q) begin
                  pool_next[p[5:0]] = pool_next[cur_q[5:0]];
                  give_node(cur_q);
                  idx = cur_q;
                  cur_q = p;
               end else st = cll_pkg::ST_EMPTY;
            end
         end
         cll_pkg::K_SEARCH: begin
            p = head_q;
            for (int n = 0; n < cll_pkg::NODES && p < cll_pkg::NODES; n++) begin
               if (alike(pool_data[p[5:0]], rq.word)) begin
                  idx = p;
                  cur_q = p;
                  break;
               end
               p = pool_next[p[5:0]];
            end
            if (idx == cll_pkg::NONE) st = cll_pkg::ST_EMPTY;
         end
         cll_pkg::K_RETRIEVE: begin
            p = head_q;
            for (int n = 0; n < rq.pos && p < cll_pkg::NODES; n++) p = pool_next[p[5:0]];
            idx = (p < cll_pkg::NODES) ? p : cll_pkg::NONE;
            if (idx == cll_pkg::NONE) st = cll_pkg::ST_EMPTY;
         end
         cll_pkg::K_CLEAR: begin
            for (int n = 0; n < cll_pkg::NODES && head_q < cll_pkg::NODES; n++)
               void'(pop_front());
            head_q = cll_pkg::NONE;
            cur_q = cll_pkg::NONE;
         end
         cll_pkg::K_PURGE: begin
            p = head_q;
            for (int n = 0; n < cll_pkg::NODES && p < cll_pkg::NODES; n++) begin
               q = p;
               for (int m = 0; m < 2 * cll_pkg::NODES && link(q) < cll_pkg::NODES; m++) begin
                  r = pool_next[q[5:0]];
                  if (alike(pool_data[p[5:0]], pool_data[r[5:0]])) begin
                     pool_next[q[5:0]] = pool_next[r[5:0]];
                     give_node(r);
                     cur_q = q;
                  end else q = r;
               end
               p = pool_next[p[5:0]];
            end
         end
         default: begin
            idx = cur_q;
            st = (cur_q < cll_pkg::NODES) ? cll_pkg::ST_OK : cll_pkg::ST_EMPTY;
         end
      endcase
      a.status = st;
      a.node = idx;
      a.cur = cur_q;
      a.cdata = (cur_q < cll_pkg::NODES) ? pool_data[cur_q[5:0]] : '0;
      return a;
   endfunction

   function automatic void add_op(logic [3:0] k, logic [31:0] w, logic [5:0] p);
      pending_q.push_back('{kind: k, word: w, pos: p, is_cfg: 0, drain: 0});
   endfunction

   function automatic void add_mask(logic [31:0] m);
      pending_q.push_back('{kind: 0, word: m, pos: 0, is_cfg: 1, drain: 0});
   endfunction

   function automatic void add_pause();
      pending_q.push_back('{kind: 0, word: 0, pos: 0, is_cfg: 0, drain: 1});
   endfunction

   // small value alphabet so searches and purges find matches
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'(($urandom_range(0, 7)) << ($urandom_range(0, 28)));
         2: return {$urandom_range(0, 1) ? 28'hFFFFFFF : 28'h0, 4'($urandom_range(0, 15))};
         default: return 32'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [3:0] pick_kind(int fill);
      int r;
      r = $urandom_range(0, 99);
      // unused codes act as read
      if (r < 2) return 4'($urandom_range(10, 15));
      if (r < 4) return cll_pkg::K_CLEAR;
      if (r < 8) return cll_pkg::K_PURGE;
      if (r < 30 + fill) return $urandom_range(0, 1) ? cll_pkg::K_INS_FRONT
                                                     : cll_pkg::K_INS_REAR;
      if (r < 45) begin
         case ($urandom_range(0, 2))
            0: return cll_pkg::K_RM_FRONT;
            1: return cll_pkg::K_RM_REAR;
            default: return cll_pkg::K_RM_CUR;
         endcase
      end
      if (r < 70) return cll_pkg::K_SEARCH;
      if (r < 88) return cll_pkg::K_RETRIEVE;
      return cll_pkg::K_READ;
   endfunction

   initial begin
      logic [31:0] masks [5];
      masks = '{32'h0, 32'h0000000F, 32'hF0000000, 32'h00FF00FF, 32'hFFFFFFFF};
      // directed: empty list, extremes, each operation
      add_op(cll_pkg::K_RM_FRONT, 0, 0);
      add_op(cll_pkg::K_RM_REAR, 0, 0);
      add_op(cll_pkg::K_RM_CUR, 0, 0);
      add_op(cll_pkg::K_SEARCH, 32'hFFFFFFFF, 0);
      add_op(cll_pkg::K_RETRIEVE, 0, 6'd63);
      add_op(cll_pkg::K_READ, 0, 0);
      add_op(4'd15, 0, 0);
      add_op(cll_pkg::K_INS_REAR, 32'hFFFFFFFF, 0);
      add_op(cll_pkg::K_RM_REAR, 0, 0);
      add_op(cll_pkg::K_INS_FRONT, 32'h0, 0);
      add_op(cll_pkg::K_INS_REAR, 32'hA5A5A5A5, 0);
      add_op(cll_pkg::K_INS_REAR, 32'h0, 0);
      add_op(cll_pkg::K_INS_FRONT, 32'hFFFFFFFF, 0);
      add_op(cll_pkg::K_SEARCH, 32'hA5A5A5A5, 0);
      add_op(cll_pkg::K_RM_CUR, 0, 0);
      add_op(cll_pkg::K_RETRIEVE, 0, 6'd2);
      add_op(cll_pkg::K_PURGE, 0, 0);
      add_op(cll_pkg::K_RM_REAR, 0, 0);
      add_op(cll_pkg::K_CLEAR, 0, 0);
      // fill the pool past full
      for (int i = 0; i < 66; i++)
         add_op(i[0] ? cll_pkg::K_INS_REAR : cll_pkg::K_INS_FRONT, 32'(i % 3), 0);
      add_op(cll_pkg::K_RETRIEVE, 0, 6'd63);
      add_op(cll_pkg::K_PURGE, 0, 0);
      add_op(cll_pkg::K_CLEAR, 0, 0);
      for (int ph = 0; ph < 5; ph++) begin
         add_pause();
         add_mask(ph == 2 ? $urandom() : masks[ph]);
         for (int i = 0; i < 185; i++) add_op(pick_kind(ph * 5), pick_word(), 6'($urandom()));
      end
      add_pause();
      add_mask(32'hFFFFFFFF);
      for (int i = 0; i < 40; i++) add_op(pick_kind(20), pick_word(), 6'($urandom()));
      stim_done = 1;
   end

   // driver
   always @(posedge clock) begin
      request_type rq;
      if (reset) begin
         start <= 0;
         csr_we <= 0;
      end else begin
         csr_we <= 0;
         if (start && !busy) begin
            start <= 0;
            awaited_q.push_back(predict_list_op(pending_q.pop_front()));
         end else if (!start && pending_q.size() > 0) begin
            rq = pending_q[0];
            if (rq.drain) begin
               if (awaited_q.size() == 0 && !busy && !rsp_valid) void'(pending_q.pop_front());
            end else if (rq.is_cfg) begin
               csr_we <= 1;
               csr_wdata <= rq.word;
               mask_q = rq.word;
               void'(pending_q.pop_front());
            end else if (calm || $urandom_range(0, 99) >= 21) begin
               start <= 1;
               req_kind <= rq.kind;
               req_data_word <= rq.word;
               req_position <= rq.pos;
            end
         end
      end
   end

   always @(posedge clock) if (!reset) calm <= (pending_q.size() > 600 && pending_q.size() < 800);

   // monitor and watchdog
   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               $display("%0t: response with none expected: %h %h %h %h", $realtime,
                        rsp_status, rsp_node_index, rsp_cursor_index, rsp_cursor_data);
               errors++;
            end else begin
               e = awaited_q.pop_front();
               if (e.status !== rsp_status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime, e.status, rsp_status);
                  errors++;
               end
               if (e.node !== rsp_node_index) begin
                  $display("%0t: node expected %0d actual %0d", $realtime, e.node,
                           rsp_node_index);
                  errors++;
               end
               if (e.cur !== rsp_cursor_index) begin
                  $display("%0t: cursor expected %0d actual %0d", $realtime, e.cur,
                           rsp_cursor_index);
                  errors++;
               end
               if (e.cdata !== rsp_cursor_data) begin
                  $display("%0t: cursor data expected %h actual %h", $realtime, e.cdata,
                           rsp_cursor_data);
                  errors++;
               end
            end
         end
         if (idle_cycles >= LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      head_q = cll_pkg::NONE;
      cur_q = cll_pkg::NONE;
      free_q = cll_pkg::NONE;
      water_q = 0;
      mask_q = 32'hFFFFFFFF;
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (stim_done);
      while (pending_q.size() > 0 || start || awaited_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== cursor_linked_list_free_list_unit.f =====
hdl/cll_pkg.sv
hdl/cll_node_store.sv
hdl/cursor_linked_list_free_list_unit.sv
tb/sv/cursor_linked_list_free_list_unit_test.sv
